@@ hw/rtl/mts_pkg.sv @@
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes of the multi timer scheduler: the slot entry kept
// in the slot memory, result and action codes, and the selector controls.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int NOW_W = 40;

   // action codes carried in req_tuser
   localparam logic [1:0] ACT_REGISTER = 2'd0;
   localparam logic [1:0] ACT_REMOVE   = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   // result kinds carried in rsp_tuser
   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_FULL   = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   // one slot as stored in the slot memory
   typedef struct packed {
      logic [7:0]       handler;
      logic [15:0]      evt;
      logic [31:0]      tag;
      logic [23:0]      period;
      logic [15:0]      limit;
      logic [15:0]      count;
      logic [NOW_W-1:0] expiry;
      logic [15:0]      stamp;
   } entry_type;

   // controls from the sequencer to the earliest-due selector
   typedef struct packed {
      logic clear;
      logic sample;
   } sel_ctl_type;

endpackage

@@ hw/rtl/multi_timer_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// multi_timer_scheduler_core
// Table of periodic or counted timers kept in one slot memory.
// ----------------------------------------------------------------------------
// Input stream req_*: req_tuser selects register, remove or tick; req_tdata
// carries the timer fields. Result stream rsp_*: rsp_tuser gives the kind,
// rsp_tdata the fired timer data, rsp_tlast marks the final result.
// Register and the unused action answer in the transfer cycle, so a result
// is presented in the cycle after the input transfer. Remove scans all slots
// through the memory read port before it answers.
// A tick makes one scan pass over all slots per due slot, disarmed or
// spent ones included, plus a final pass and the done result, as set by the
// single read port of the slot memory.
// A result waits in the output register while rsp_tready is low; the
// sequencer then holds before its next result, and the next input is
// taken as soon as the register is free or being emptied.
// Reset clears all valid and armed bits, the millisecond clock and the
// insertion stamp; the slot memory itself needs no clearing.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_core #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // handler[7:0], event_id[23:8], period_ms[47:24], repeat_limit[63:48],
   // user_tag[95:64]
   input  logic [95:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fired_handler[7:0], fired_event[23:8], fired_tag[55:24],
   // fire_count[71:56]
   output logic [71:0] rsp_tdata,
   // kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import mts_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_RM_SCAN = 6'b000010,
      ST_RM_RESP = 6'b000100,
      ST_TK_SCAN = 6'b001000,
      ST_TK_FIRE = 6'b010000,
      ST_TK_DONE = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [SLOTS-1:0] armed_ff, armed_in;
   logic [SLOTS-1:0] done_ff, done_in;
   logic [NOW_W-1:0] now_ff, now_in;
   logic [15:0]      stamp_ff, stamp_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic             issue_ff, issue_in;
   logic             rvld_ff, rvld_in;
   logic [IW-1:0]    ridx_ff, ridx_in;
   logic [7:0]       hh_ff, hh_in;
   logic [15:0]      he_ff, he_in;
   logic             rsp_vld_ff, rsp_vld_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_h_ff, rsp_h_in;
   logic [15:0]      rsp_e_ff, rsp_e_in;
   logic [31:0]      rsp_t_ff, rsp_t_in;
   logic [15:0]      rsp_c_ff, rsp_c_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             rsp_free, accept, full;
   logic [IW-1:0]    free_idx;
   logic [23:0]      period;
   logic [15:0]      new_count;
   logic             dead;
   logic             wr_en;
   logic [IW-1:0]    wr_addr;
   entry_type        wr_data, rd_data;
   sel_ctl_type      sel_ctl;
   logic             sel_found;
   logic [IW-1:0]    sel_idx;
   entry_type        sel_entry;

   // slot memory
   mts_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // earliest-due selection during tick scans
   mts_select #(
      .SLOTS (SLOTS)
   ) u_select (
      .clock      (clock),
      .reset      (reset),
      .ctl        (sel_ctl),
      .entry      (rd_data),
      .idx        (ridx_ff),
      .now        (now_ff),
      .stamp      (stamp_ff),
      .found      (sel_found),
      .best_idx   (sel_idx),
      .best_entry (sel_entry)
   );

   // lowest free slot
   always_comb begin
      full     = &valid_ff;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
         end
      end
   end

   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign period     = (req_tdata[47:24] == 24'd0) ? 24'd1 : req_tdata[47:24];

   // sequencer
   always_comb begin
      state_in    = state_ff;
      valid_in    = valid_ff;
      armed_in    = armed_ff;
      done_in     = done_ff;
      now_in      = now_ff;
      stamp_in    = stamp_ff;
      idx_in      = idx_ff;
      issue_in    = issue_ff;
      rvld_in     = issue_ff &&
                    ((state_ff == ST_RM_SCAN) || (state_ff == ST_TK_SCAN));
      ridx_in     = idx_ff;
      hh_in       = hh_ff;
      he_in       = he_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_kind_in = rsp_kind_ff;
      rsp_h_in    = rsp_h_ff;
      rsp_e_in    = rsp_e_ff;
      rsp_t_in    = rsp_t_ff;
      rsp_c_in    = rsp_c_ff;
      rsp_last_in = rsp_last_ff;
      wr_en       = 1'b0;
      wr_addr     = free_idx;
      wr_data     = '0;
      sel_ctl     = '0;
      new_count   = (sel_entry.count == 16'hFFFF) ? sel_entry.count
                                                  : sel_entry.count + 16'd1;
      dead        = !armed_ff[sel_idx] ||
                    ((sel_entry.limit != 16'd0) && (sel_entry.count >= sel_entry.limit));

      // scan address issue
      if (issue_ff && ((state_ff == ST_RM_SCAN) || (state_ff == ST_TK_SCAN))) begin
         if (idx_ff == LAST_IDX) begin
            issue_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_h_in    = '0;
               rsp_e_in    = '0;
               rsp_t_in    = '0;
               rsp_c_in    = '0;
               rsp_last_in = 1'b1;
               unique case (req_tuser)
                  ACT_REGISTER: begin
                     rsp_vld_in = 1'b1;
                     if (full) begin
                        rsp_kind_in = KIND_FULL;
                     end else begin
                        rsp_kind_in        = KIND_ACCEPT;
                        wr_en              = 1'b1;
                        wr_data.handler    = req_tdata[7:0];
                        wr_data.evt        = req_tdata[23:8];
                        wr_data.period     = period;
                        wr_data.limit      = req_tdata[63:48];
                        wr_data.tag        = req_tdata[95:64];
                        wr_data.count      = '0;
                        wr_data.expiry     = now_ff + NOW_W'(period);
                        wr_data.stamp      = stamp_ff;
                        stamp_in           = stamp_ff + 16'd1;
                        valid_in[free_idx] = 1'b1;
                        armed_in[free_idx] = 1'b1;
                     end
                  end
                  ACT_REMOVE: begin
                     hh_in    = req_tdata[7:0];
                     he_in    = req_tdata[23:8];
                     idx_in   = '0;
                     issue_in = 1'b1;
                     state_in = ST_RM_SCAN;
                  end
                  ACT_TICK: begin
                     now_in      = now_ff + 1'b1;
                     done_in     = '0;
                     sel_ctl.clear = 1'b1;
                     idx_in      = '0;
                     issue_in    = 1'b1;
                     state_in    = ST_TK_SCAN;
                  end
                  default: begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = KIND_ACCEPT;
                  end
               endcase
            end
         end
         ST_RM_SCAN: begin
            if (rvld_ff) begin
               if (valid_ff[ridx_ff] && (rd_data.handler == hh_ff) &&
                   ((he_ff == 16'd0) || (rd_data.evt == he_ff))) begin
                  armed_in[ridx_ff] = 1'b0;
               end
               if (ridx_ff == LAST_IDX) begin
                  state_in = ST_RM_RESP;
               end
            end
         end
         ST_RM_RESP: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = KIND_ACCEPT;
               rsp_h_in    = '0;
               rsp_e_in    = '0;
               rsp_t_in    = '0;
               rsp_c_in    = '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_TK_SCAN: begin
            sel_ctl.sample = rvld_ff && valid_ff[ridx_ff] && !done_ff[ridx_ff];
            if (rvld_ff && (ridx_ff == LAST_IDX)) begin
               state_in = ST_TK_FIRE;
            end
         end
         ST_TK_FIRE: begin
            if (!sel_found) begin
               state_in = ST_TK_DONE;
            end else if (dead) begin
               // disarmed or spent: freed without a result
               valid_in[sel_idx] = 1'b0;
               armed_in[sel_idx] = 1'b0;
               done_in[sel_idx]  = 1'b1;
               sel_ctl.clear     = 1'b1;
               idx_in            = '0;
               issue_in          = 1'b1;
               state_in          = ST_TK_SCAN;
            end else if (rsp_free) begin
               rsp_vld_in     = 1'b1;
               rsp_kind_in    = KIND_FIRED;
               rsp_h_in       = sel_entry.handler;
               rsp_e_in       = sel_entry.evt;
               rsp_t_in       = sel_entry.tag;
               rsp_c_in       = new_count;
               rsp_last_in    = 1'b0;
               // rearm in place
               wr_en          = 1'b1;
               wr_addr        = sel_idx;
               wr_data        = sel_entry;
               wr_data.count  = new_count;
               wr_data.expiry = now_ff + NOW_W'(sel_entry.period);
               wr_data.stamp  = stamp_ff;
               stamp_in       = stamp_ff + 16'd1;
               if ((sel_entry.limit != 16'd0) && (new_count >= sel_entry.limit)) begin
                  valid_in[sel_idx] = 1'b0;
                  armed_in[sel_idx] = 1'b0;
               end
               done_in[sel_idx] = 1'b1;
               sel_ctl.clear    = 1'b1;
               idx_in           = '0;
               issue_in         = 1'b1;
               state_in         = ST_TK_SCAN;
            end
         end
         ST_TK_DONE: begin
            if (rsp_free) begin
               rsp_vld_in  = 1'b1;
               rsp_kind_in = KIND_DONE;
               rsp_h_in    = '0;
               rsp_e_in    = '0;
               rsp_t_in    = '0;
               rsp_c_in    = '0;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         valid_ff   <= '0;
         armed_ff   <= '0;
         now_ff     <= '0;
         stamp_ff   <= '0;
         issue_ff   <= 1'b0;
         rvld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         armed_ff   <= armed_in;
         now_ff     <= now_in;
         stamp_ff   <= stamp_in;
         issue_ff   <= issue_in;
         rvld_ff    <= rvld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      done_ff     <= done_in;
      idx_ff      <= idx_in;
      ridx_ff     <= ridx_in;
      hh_ff       <= hh_in;
      he_ff       <= he_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_e_ff    <= rsp_e_in;
      rsp_t_ff    <= rsp_t_in;
      rsp_c_ff    <= rsp_c_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_c_ff, rsp_t_ff, rsp_e_ff, rsp_h_ff};

   // a slot fires at most once per tick
   a_once_per_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_FIRE && sel_found) |-> !done_ff[sel_idx])
      else $error("slot selected twice in one tick");

   // a register transfer never overwrites a live slot
   a_free_slot: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_IDLE) |-> !valid_ff[wr_addr])
      else $error("register wrote a valid slot");

   // a fired result never carries the last flag
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_kind_ff == KIND_FIRED) |-> !rsp_last_ff)
      else $error("fired result marked last");

   // the memory is never written while a scan is reading it
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_SCAN || state_ff == ST_RM_SCAN) |-> !wr_en)
      else $error("slot write during scan");

endmodule

@@ hw/rtl/mts_ram.sv @@
// ----------------------------------------------------------------------------
// mts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/mts_select.sv @@
// ----------------------------------------------------------------------------
// mts_select
// Earliest-due selector: watches slot entries streamed out of the slot
// memory and keeps the due one with the lowest expiry, oldest stamp on ties.
// ----------------------------------------------------------------------------
module mts_select #(
   parameter int SLOTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mts_pkg::sel_ctl_type       ctl,
   input  mts_pkg::entry_type         entry,
   input  logic [$clog2(SLOTS)-1:0]   idx,
   input  logic [mts_pkg::NOW_W-1:0]  now,
   input  logic [15:0]                stamp,
   output logic                       found,
   output logic [$clog2(SLOTS)-1:0]   best_idx,
   output mts_pkg::entry_type         best_entry
);
   import mts_pkg::*;

   localparam int IW = $clog2(SLOTS);

   logic            found_ff, found_in;
   logic [IW-1:0]   idx_ff, idx_in;
   entry_type       entry_ff, entry_in;
   logic [15:0]     age_ff, age_in;
   logic [15:0]     age;
   logic            due, better;

   // compare the incoming entry against the best so far
   always_comb begin
      age    = stamp - entry.stamp;
      due    = entry.expiry <= now;
      better = !found_ff || (entry.expiry < entry_ff.expiry) ||
               ((entry.expiry == entry_ff.expiry) && (age > age_ff));
      found_in = found_ff;
      idx_in   = idx_ff;
      entry_in = entry_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && due && better) begin
         found_in = 1'b1;
         idx_in   = idx;
         entry_in = entry;
         age_in   = age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      entry_ff <= entry_in;
      age_ff   <= age_in;
   end

   assign found      = found_ff;
   assign best_idx   = idx_ff;
   assign best_entry = entry_ff;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi timer scheduler core. A queue of timer
// commands (register, remove, tick, unused action) feeds a stream driver with
// random gaps, and a software timer table predicts every result. A monitor
// with random back pressure, and one long hold-off, checks each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import mts_pkg::*;

   localparam int         SLOTS       = 16;
   localparam logic [1:0] ACT_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 2000000;
   localparam int         DRAIN_WAIT  = 400;
   localparam int         HOLD_CYCLES = 600;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  handler;
      logic [15:0] evt;
      logic [23:0] period;
      logic [15:0] limit;
      logic [31:0] tag;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  handler;
      logic [15:0] evt;
      logic [31:0] tag;
      logic [15:0] count;
      logic        last;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   cmd_type    cmd_q[$];
   result_type expected_q[$];
   cmd_type    cur_cmd;
   int      errors = 0;
   int      cycles = 0;
   int      sent   = 0;
   bit      req_taken = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   int      hold_left = 0;
   bit      hold_done = 1'b0;

   // timer table shadow
   bit          t_valid[SLOTS];
   bit          t_armed[SLOTS];
   logic [7:0]  t_handler[SLOTS];
   logic [15:0] t_event[SLOTS];
   logic [31:0] t_tag[SLOTS];
   logic [23:0] t_period[SLOTS];
   logic [15:0] t_limit[SLOTS];
   logic [15:0] t_count[SLOTS];
   logic [39:0] t_expiry[SLOTS];
   logic [15:0] t_stamp[SLOTS];
   logic [39:0] now_ms = '0;
   logic [15:0] next_stamp = '0;

   multi_timer_scheduler_core #(.SLOTS(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic result_type mk_result(logic [1:0] kind, int s, logic last);
      result_type r;
      r = '0;
      r.kind = kind;
      r.last = last;
      if (s >= 0) begin
         r.handler = t_handler[s];
         r.evt     = t_event[s];
         r.tag     = t_tag[s];
         r.count   = t_count[s];
      end
      return r;
   endfunction

   // expected results of one accepted command, table updated in place
   function automatic void predict_timers(cmd_type c);
      bit          handled[SLOTS];
      int          slot;
      int          best;
      logic [15:0] age;
      logic [15:0] best_age;
      logic [23:0] per;
      slot = -1;
      best_age = '0;
      case (c.action)
         ACT_REGISTER: begin
            for (int i = SLOTS - 1; i >= 0; i--) if (!t_valid[i]) slot = i;
            if (slot < 0) begin
               expected_q.push_back(mk_result(KIND_FULL, -1, 1'b1));
            end else begin
               per = (c.period == 0) ? 24'd1 : c.period;
               t_valid[slot] = 1; t_armed[slot] = 1;
               t_handler[slot] = c.handler; t_event[slot] = c.evt;
               t_tag[slot] = c.tag; t_period[slot] = per;
               t_limit[slot] = c.limit; t_count[slot] = '0;
               t_expiry[slot] = now_ms + per;
               t_stamp[slot] = next_stamp; next_stamp++;
               expected_q.push_back(mk_result(KIND_ACCEPT, -1, 1'b1));
            end
         end
         ACT_REMOVE: begin
            for (int i = 0; i < SLOTS; i++)
               if (t_valid[i] && t_handler[i] == c.handler &&
                   (c.evt == 0 || t_event[i] == c.evt)) t_armed[i] = 0;
            expected_q.push_back(mk_result(KIND_ACCEPT, -1, 1'b1));
         end
         ACT_TICK: begin
            for (int i = 0; i < SLOTS; i++) handled[i] = 0;
            now_ms++;
            forever begin
               best = -1;
               for (int i = 0; i < SLOTS; i++) begin
                  if (!t_valid[i] || handled[i] || t_expiry[i] > now_ms) continue;
                  age = next_stamp - t_stamp[i];
                  if (best < 0 || t_expiry[i] < t_expiry[best] ||
                      (t_expiry[i] == t_expiry[best] && age > best_age)) begin
                     best = i;
                     best_age = age;
                  end
               end
               if (best < 0) break;
               handled[best] = 1;
               // disarmed or already exhausted: freed without firing
               if (!t_armed[best] ||
                   (t_limit[best] != 0 && t_count[best] >= t_limit[best])) begin
                  t_valid[best] = 0; t_armed[best] = 0;
                  continue;
               end
               if (t_count[best] != 16'hFFFF) t_count[best]++;
               expected_q.push_back(mk_result(KIND_FIRED, best, 1'b0));
               t_expiry[best] = now_ms + t_period[best];
               t_stamp[best] = next_stamp; next_stamp++;
               if (t_limit[best] != 0 && t_count[best] >= t_limit[best]) begin
                  t_valid[best] = 0; t_armed[best] = 0;
               end
            end
            expected_q.push_back(mk_result(KIND_DONE, -1, 1'b1));
         end
         default: expected_q.push_back(mk_result(KIND_ACCEPT, -1, 1'b1));
      endcase
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 5) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic cmd_type mk_cmd(logic [1:0] a, logic [7:0] h, logic [15:0] e,
                                      logic [23:0] p, logic [15:0] l, logic [31:0] t);
      cmd_type c;
      c.action = a; c.handler = h; c.evt = e; c.period = p; c.limit = l; c.tag = t;
      return c;
   endfunction

   // random command mix: mostly small handler/event sets so removes hit
   function automatic cmd_type rand_cmd();
      cmd_type c;
      int   sel;
      sel = $urandom_range(0, 99);
      c.handler = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
      c.evt     = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(1, 3)) : 16'($urandom);
      c.period  = 24'($urandom_range(0, 12));
      c.limit   = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4)) : 16'($urandom);
      c.tag     = $urandom;
      if (sel < 35) c.action = ACT_REGISTER;
      else if (sel < 45) begin
         c.action = ACT_REMOVE;
         if ($urandom_range(0, 2) == 0) c.evt = '0;
         c.period = 24'($urandom);
      end else if (sel < 96) begin
         c.action = ACT_TICK;
         c.period = 24'($urandom);
      end else c.action = ACT_UNUSED;
      return c;
   endfunction

   // stimulus and end of run
   initial begin
      cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'hFF, 16'hFFFF, 24'd0, 16'hFFFF, 32'hFFFFFFFF));
      cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'h00, 16'h0000, 24'd1, 16'd1, 32'h0));
      cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'h01, 16'h0005, 24'd1, 16'd2, 32'h12345678));
      cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'h01, 16'h0006, 24'd2, 16'd0, 32'hA5A5A5A5));
      cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'h02, 16'h0007, 24'hFFFFFF, 16'd0, 32'h5A5A5A5A));
      cmd_q.push_back(mk_cmd(ACT_TICK, '0, '0, '0, '0, '0));
      cmd_q.push_back(mk_cmd(ACT_TICK, '1, '1, '1, '1, '1));
      cmd_q.push_back(mk_cmd(ACT_REMOVE, 8'h01, 16'h0005, '0, '0, '0));
      cmd_q.push_back(mk_cmd(ACT_REMOVE, 8'h77, 16'h0000, '0, '0, '0));
      cmd_q.push_back(mk_cmd(ACT_TICK, '0, '0, '0, '0, '0));
      cmd_q.push_back(mk_cmd(ACT_REMOVE, 8'hFF, 16'h0000, '1, '1, '1));
      cmd_q.push_back(mk_cmd(ACT_UNUSED, '1, '1, '1, '1, '1));
      cmd_q.push_back(mk_cmd(ACT_TICK, '0, '0, '0, '0, '0));
      // register twelve timers of one period for tie order; the table stays short of full
      for (int i = 0; i < 12; i++)
         cmd_q.push_back(mk_cmd(ACT_REGISTER, 8'(i), 16'(i + 1), 24'd3, 16'd2, $urandom));
      for (int i = 0; i < 360; i++) cmd_q.push_back(rand_cmd());

      repeat (6) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      while (cmd_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("multi_timer_scheduler_core test passed");
      else $display("multi_timer_scheduler_core test failed");
      $finish;
   end

   // input driver: next command after the previous transfer and a random gap, which may be zero
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (req_taken && req_gap == 0) req_gap = pick_gap();
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (cmd_q.size() != 0) begin
            cur_cmd = cmd_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= cur_cmd.action;
            req_tdata  <= {cur_cmd.tag, cur_cmd.limit, cur_cmd.period,
                           cur_cmd.evt, cur_cmd.handler};
            req_gap = 0;
         end else req_tvalid <= 1'b0;
      end
   end

   // result ready: random gaps, one long hold-off mid run
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && sent == 120) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_gap = pick_gap();
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor: prediction on input transfer, check on result transfer
   always @(posedge clock) begin
      result_type got;
      result_type want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("multi_timer_scheduler_core test failed");
         $finish;
      end
      req_taken = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.handler = rsp_tdata[7:0];
         got.evt = rsp_tdata[23:8];
         got.tag = rsp_tdata[55:24];
         got.count = rsp_tdata[71:56];
         got.last = rsp_tlast;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected: kind %0d", got.kind);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.kind != want.kind) begin
               $error("kind: expected %0d actual %0d", want.kind, got.kind); errors++;
            end
            if (got.handler != want.handler) begin
               $error("fired_handler: expected %0h actual %0h", want.handler, got.handler);
               errors++;
            end
            if (got.evt != want.evt) begin
               $error("fired_event: expected %0h actual %0h", want.evt, got.evt); errors++;
            end
            if (got.tag != want.tag) begin
               $error("fired_tag: expected %0h actual %0h", want.tag, got.tag); errors++;
            end
            if (got.count != want.count) begin
               $error("fire_count: expected %0d actual %0d", want.count, got.count);
               errors++;
            end
            if (got.last != want.last) begin
               $error("last: expected %0d actual %0d", want.last, got.last); errors++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         predict_timers(cur_cmd);
         req_taken = 1'b1;
         sent++;
      end
   end

endmodule
